### rtl/ir_pulse_distance_receiver_core_assert.svh
// Assertion macros shared by the receiver RTL.
`ifndef IR_PULSE_DISTANCE_RECEIVER_CORE_ASSERT_SVH
`define IR_PULSE_DISTANCE_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/irpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

  // Item kinds on the input channel.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  // Number of ticks that land in the early window.
  localparam logic [5:0] EARLY_LEN = 6'd32;
  // Saturation point of the sample counter.
  localparam logic [5:0] COUNT_MAX = 6'd63;

  // Configuration port index width and register indexes.
  localparam int unsigned CFG_INDEX_W = 8;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_EARLY_MAX = 8'd0,
    REG_HEADER_LATE_MIN  = 8'd1,
    REG_ONE_THRESHOLD    = 8'd2,
    REG_HEADER_SAMPLES   = 8'd3
  } irpd_reg_t;

  // Register values after reset.
  localparam logic [31:0] RST_HEADER_EARLY_MAX = 32'd16;
  localparam logic [31:0] RST_HEADER_LATE_MIN  = 32'd500;
  localparam logic [31:0] RST_ONE_THRESHOLD    = 32'd3;
  localparam logic [5:0]  RST_HEADER_SAMPLES   = 6'd40;

  typedef struct packed {
    logic [31:0] header_early_max;
    logic [31:0] header_late_min;
    logic [31:0] one_threshold;
    logic [5:0]  header_samples;
  } irpd_cfg_t;

  // Decoder state apart from the bit counter, whose width follows the frame length.
  typedef struct packed {
    logic [5:0]  sample_count;
    logic [31:0] early_window;
    logic [31:0] late_window;
    logic        capture_active;
    logic [31:0] frame_shift;
    logic [31:0] last_frame;
    logic        sample_enable;
  } irpd_state_t;

endpackage

`default_nettype wire

### rtl/irpd_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic of the decoder for one item.
module irpd_step import irpd_pkg::*; #(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned BIT_W      = $clog2(FRAME_BITS + 1)
) (
  input  wire logic             func,
  input  wire logic             ir_level,
  input  wire irpd_cfg_t        cfg,
  input  wire irpd_state_t      cur,
  input  wire logic [BIT_W-1:0] bit_count,
  output      irpd_state_t      nxt,
  output      logic [BIT_W-1:0] bit_count_next,
  output      logic             done
);

  logic        one_bit;
  logic [31:0] frame_or;
  logic [5:0]  count_inc;

  assign one_bit   = (cur.early_window > cfg.one_threshold);
  assign frame_or  = cur.frame_shift | {31'd0, one_bit};
  assign count_inc = (cur.sample_count < COUNT_MAX) ? cur.sample_count + 6'd1
                                                    : cur.sample_count;

  always_comb begin
    nxt            = cur;
    bit_count_next = bit_count;
    done           = 1'b0;
    if (func == FUNC_EDGE) begin
      // An edge appends one bit while capturing: set bit 0, then shift.
      if (cur.capture_active) begin
        nxt.frame_shift = {frame_or[30:0], 1'b0};
        bit_count_next  = bit_count + 1'b1;
        if (bit_count_next == BIT_W'(FRAME_BITS)) begin
          nxt.last_frame     = {frame_or[30:0], 1'b0};
          nxt.capture_active = 1'b0;
          done               = 1'b1;
        end
      end
      // Every edge restarts the sampling of the next gap.
      nxt.sample_count  = 6'd0;
      nxt.early_window  = 32'd0;
      nxt.late_window   = 32'd0;
      nxt.sample_enable = 1'b1;
    end else if (cur.sample_enable) begin
      // A tick shifts the level into the early or the late window.
      if (cur.sample_count < EARLY_LEN) begin
        nxt.early_window = {cur.early_window[30:0], ir_level};
      end else begin
        nxt.late_window = {cur.late_window[30:0], ir_level};
      end
      nxt.sample_count = count_inc;
      // Past the header length outside a frame: stop and check the header.
      if (count_inc > cfg.header_samples && !cur.capture_active) begin
        nxt.sample_enable = 1'b0;
        if (nxt.early_window < cfg.header_early_max &&
            nxt.late_window > cfg.header_late_min) begin
          nxt.capture_active = 1'b1;
          nxt.frame_shift    = 32'd0;
          bit_count_next     = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ir_pulse_distance_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------
// in       in_valid / in_ready  func, ir_level
// out      out_valid/out_ready  frame_ready, frame_value, capturing, sampling_on
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item's result is loaded into the output register at the clock edge that accepts it.
// One item per cycle is sustained while out does not stall; the single decode step sets this figure.
// in_ready is high whenever the output register is empty or being drained.
// A stall on out holds the result and stops input only while the register stays full.
// Synchronous reset clears all decoder state and loads the register defaults; cfg_ready is always high.

`include "ir_pulse_distance_receiver_core_assert.svh"

module ir_pulse_distance_receiver_core import irpd_pkg::*; #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   func,
  input  wire logic                   ir_level,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic                   frame_ready,
  output      logic [31:0]            frame_value,
  output      logic                   capturing,
  output      logic                   sampling_on,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int unsigned BIT_W = $clog2(FRAME_BITS + 1);

  irpd_cfg_t        cfg;
  irpd_state_t      state;
  irpd_state_t      state_next;
  logic [BIT_W-1:0] bit_count;
  logic [BIT_W-1:0] bit_count_next;
  logic             done;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_early_max <= RST_HEADER_EARLY_MAX;
      cfg.header_late_min  <= RST_HEADER_LATE_MIN;
      cfg.one_threshold    <= RST_ONE_THRESHOLD;
      cfg.header_samples   <= RST_HEADER_SAMPLES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_EARLY_MAX: cfg.header_early_max <= cfg_data;
        REG_HEADER_LATE_MIN:  cfg.header_late_min  <= cfg_data;
        REG_ONE_THRESHOLD:    cfg.one_threshold    <= cfg_data;
        REG_HEADER_SAMPLES:   cfg.header_samples   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  irpd_step #(
    .FRAME_BITS (FRAME_BITS),
    .BIT_W      (BIT_W)
  ) u_step (
    .func           (func),
    .ir_level       (ir_level),
    .cfg            (cfg),
    .cur            (state),
    .bit_count      (bit_count),
    .nxt            (state_next),
    .bit_count_next (bit_count_next),
    .done           (done)
  );

  // Decoder state advances on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      bit_count <= '0;
    end else if (in_fire) begin
      state     <= state_next;
      bit_count <= bit_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_ready <= done;
      frame_value <= state_next.last_frame;
      capturing   <= state_next.capture_active;
      sampling_on <= state_next.sample_enable;
    end
  end

  `IRPD_ASSERT_NOW(a_frame_ends_capture, out_valid && frame_ready, !capturing, "frame result while still capturing")
  `IRPD_ASSERT_NOW(a_bit_count_range, state.capture_active, bit_count < BIT_W'(FRAME_BITS), "bit counter past frame length during capture")
  `IRPD_ASSERT_NEXT(a_edge_restarts, in_fire && func == FUNC_EDGE, state.sample_enable && state.sample_count == 6'd0, "edge did not restart sampling")
  `IRPD_ASSERT_NOW(a_capture_start_clear, $rose(state.capture_active), bit_count == '0 && state.frame_shift == 32'd0, "capture started with stale frame state")

endmodule

`default_nettype wire

### tb/sv/ir_pulse_distance_receiver_core_test.sv
`timescale 1ns / 1ps

module ir_pulse_distance_receiver_core_test;
  import irpd_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int FRAME_LEN = 32;
  localparam int ITEM_GOAL = 1300;
  localparam int PHASES = 7;
  localparam int REG_COUNT = 4;
  localparam int IDLE_PCT = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int FRAME_SLACK = 60;
  localparam longint LIMIT_NS = 64'd2_000_000;

  // One result of the receiver, in port order.
  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic        cap;
    logic        samp;
  } rx_result_t;

  // One input item, with an optional hand-written expectation.
  typedef struct packed {
    logic       f;
    logic       lv;
    logic       typed;
    rx_result_t want;
  } stim_item_t;

  localparam rx_result_t RX_QUIET  = '{1'b0, 32'd0, 1'b0, 1'b0};
  localparam rx_result_t RX_LISTEN = '{1'b0, 32'd0, 1'b0, 1'b1};
  localparam rx_result_t RX_ANY    = '{1'b0, 32'd0, 1'b0, 1'b0};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   func = FUNC_TICK;
  logic                   ir_level = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   frame_ready;
  logic [31:0]            frame_value;
  logic                   capturing;
  logic                   sampling_on;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  // Shadow copy of the decoder state and its registers.
  logic [5:0]  m_count = '0;
  logic [31:0] m_early = '0;
  logic [31:0] m_late = '0;
  logic        m_capture = 1'b0;
  logic [5:0]  m_bits = '0;
  logic [31:0] m_shift = '0;
  logic [31:0] m_frame = '0;
  logic        m_sampling = 1'b0;
  logic [31:0] c_early_max = RST_HEADER_EARLY_MAX;
  logic [31:0] c_late_min = RST_HEADER_LATE_MIN;
  logic [31:0] c_one_thr = RST_ONE_THRESHOLD;
  logic [5:0]  c_hdr_samples = RST_HEADER_SAMPLES;

  stim_item_t stim_q[$];
  rx_result_t rx_expect_q[$];
  logic       in_ready_n = 1'b0;
  bit         calm = 1'b0;
  int         live_items = 0;
  int         errors = 0;

  // Opening items after reset: ignored ticks, edges with either level, short windows.
  stim_item_t directed_tbl [12] = '{
    '{FUNC_TICK, 1'b1, 1'b1, RX_QUIET},
    '{FUNC_TICK, 1'b0, 1'b1, RX_QUIET},
    '{FUNC_EDGE, 1'b1, 1'b1, RX_LISTEN},
    '{FUNC_TICK, 1'b1, 1'b0, RX_ANY},
    '{FUNC_TICK, 1'b1, 1'b0, RX_ANY},
    '{FUNC_TICK, 1'b0, 1'b0, RX_ANY},
    '{FUNC_EDGE, 1'b0, 1'b1, RX_LISTEN},
    '{FUNC_EDGE, 1'b1, 1'b1, RX_LISTEN},
    '{FUNC_TICK, 1'b0, 1'b0, RX_ANY},
    '{FUNC_TICK, 1'b1, 1'b0, RX_ANY},
    '{FUNC_EDGE, 1'b0, 1'b1, RX_LISTEN},
    '{FUNC_TICK, 1'b1, 1'b0, RX_ANY}
  };

  ir_pulse_distance_receiver_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .ir_level   (ir_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_ready(frame_ready),
    .frame_value(frame_value),
    .capturing  (capturing),
    .sampling_on(sampling_on),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advance the shadow decoder by one item and return the result it shows.
  function automatic rx_result_t decode_item(input logic f, input logic lv);
    rx_result_t r;
    r.done = 1'b0;
    if (f == FUNC_EDGE) begin
      if (m_capture) begin
        // The bit goes into bit 0 before the shift, so bit 0 of a frame stays clear.
        if (m_early > c_one_thr) m_shift[0] = 1'b1;
        m_shift = m_shift << 1;
        m_bits = m_bits + 6'd1;
        if (m_bits == FRAME_LEN) begin
          m_frame = m_shift;
          m_capture = 1'b0;
          r.done = 1'b1;
        end
      end
      m_count = '0;
      m_early = '0;
      m_late = '0;
      m_sampling = 1'b1;
    end else if (m_sampling) begin
      if (m_count < EARLY_LEN) m_early = {m_early[30:0], lv};
      else m_late = {m_late[30:0], lv};
      if (m_count < COUNT_MAX) m_count = m_count + 6'd1;
      // Header check happens at most once per gap, when the counter passes the header length.
      if (m_count > c_hdr_samples && !m_capture) begin
        m_sampling = 1'b0;
        if (m_early < c_early_max && m_late > c_late_min) begin
          m_capture = 1'b1;
          m_bits = '0;
          m_shift = '0;
        end
      end
    end
    r.word = m_frame;
    r.cap = m_capture;
    r.samp = m_sampling;
    return r;
  endfunction

  function automatic void load_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_HEADER_EARLY_MAX: c_early_max = d;
      REG_HEADER_LATE_MIN:  c_late_min = d;
      REG_ONE_THRESHOLD:    c_one_thr = d;
      REG_HEADER_SAMPLES:   c_hdr_samples = d[5:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Feed items from the queue; predict each one at the edge that accepts it.
  always @(posedge clk) begin : feed
    stim_item_t head;
    rx_result_t r;
    if (!rst) begin
      if (in_valid && in_ready_n) begin
        head = stim_q.pop_front();
        if (!(head.f == FUNC_TICK && !m_sampling)) live_items++;
        r = decode_item(head.f, head.lv);
        rx_expect_q.push_back(head.typed ? head.want : r);
      end
      if (!(in_valid && !in_ready_n)) begin
        if (stim_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          func <= stim_q[0].f;
          ir_level <= stim_q[0].lv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The result side stalls at random too.
  always @(posedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Sample handshakes mid-cycle; an item seen here is taken at the next rising edge.
  always @(negedge clk) begin : check
    rx_result_t w;
    in_ready_n = in_ready;
    if (!rst && out_valid && out_ready) begin
      if (rx_expect_q.size() == 0) begin
        report_mismatch("unexpected result", frame_value, 32'd0);
      end else begin
        w = rx_expect_q.pop_front();
        if (frame_ready !== w.done) report_mismatch("frame_ready", 32'(frame_ready), 32'(w.done));
        if (frame_value !== w.word) report_mismatch("frame_value", frame_value, w.word);
        if (capturing !== w.cap) report_mismatch("capturing", 32'(capturing), 32'(w.cap));
        if (sampling_on !== w.samp) report_mismatch("sampling_on", 32'(sampling_on), 32'(w.samp));
      end
    end
  end

  task automatic queue_row(input stim_item_t it);
    while (stim_q.size() >= QUEUE_DEPTH) @(posedge clk);
    stim_q.push_back(it);
  endtask

  task automatic queue_item(input logic f, input logic lv);
    queue_row('{f, lv, 1'b0, RX_ANY});
  endtask

  // Wait until every item is taken and every result has come back.
  task automatic drain;
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (rx_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    load_reg(idx, d);
  endtask

  // Write all four registers, and with spare one unused index; the header length gets random upper bits.
  task automatic program_regs(input logic [31:0] em, input logic [31:0] lm,
                              input logic [31:0] thr, input int hs, input bit spare);
    write_reg(REG_HEADER_EARLY_MAX, em);
    write_reg(REG_HEADER_LATE_MIN, lm);
    write_reg(REG_ONE_THRESHOLD, thr);
    write_reg(REG_HEADER_SAMPLES, ($urandom() << 6) | 32'(hs & 63));
    if (spare)
      write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1)),
                $urandom());
    cfg_valid <= 1'b0;
  endtask

  // An edge, a header that should pass, then the frame bits, each closed by an edge.
  // A broken frame gets flipped header samples and may stop early.
  task automatic send_frame(input bit broken);
    int n_hdr;
    int n_bits;
    int n_ticks;
    int i;
    int b;
    logic [31:0] pattern;
    logic lv;
    queue_item(FUNC_EDGE, 1'($urandom_range(1)));
    n_hdr = (c_hdr_samples == COUNT_MAX) ? $urandom_range(64, 80) : int'(c_hdr_samples) + 1;
    for (i = 0; i < n_hdr; i++) begin
      if (i < int'(EARLY_LEN)) lv = (i >= int'(EARLY_LEN) - 4) ? 1'($urandom_range(1)) : 1'b0;
      else lv = 1'b1;
      if (broken && $urandom_range(99) < 5) lv = ~lv;
      queue_item(FUNC_TICK, lv);
    end
    // A few ticks after the header should be ignored.
    repeat ($urandom_range(0, 2)) queue_item(FUNC_TICK, 1'($urandom_range(1)));
    case ($urandom_range(3))
      0: pattern = '1;
      1: pattern = '0;
      default: pattern = $urandom();
    endcase
    n_bits = broken ? $urandom_range(1, FRAME_LEN) : FRAME_LEN;
    for (b = 0; b < n_bits; b++) begin
      n_ticks = pattern[b] ? $urandom_range(3, 6) : $urandom_range(0, 2);
      // Now and then a long gap that can drive the counter into saturation.
      if ($urandom_range(49) == 0) n_ticks = $urandom_range(60, 70);
      for (i = 0; i < n_ticks; i++)
        queue_item(FUNC_TICK, pattern[b] ? 1'b1 : 1'($urandom_range(1)));
      queue_item(FUNC_EDGE, 1'($urandom_range(1)));
    end
  endtask

  task automatic send_noise;
    repeat ($urandom_range(5, 40))
      queue_item($urandom_range(99) < 25 ? FUNC_EDGE : FUNC_TICK, 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int p;
    int hs;
    int late_all;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_tbl[k]) queue_row(directed_tbl[k]);
    drain();
    for (p = 0; p < PHASES; p++) begin
      // Settings: reset values, two sets of extremes, then random ones.
      case (p)
        0: ;
        1: program_regs('1, '0, '0, 32, 1'b0);
        2: program_regs('0, '1, '1, int'(COUNT_MAX), 1'b0);
        3: program_regs($urandom(), $urandom(), $urandom(), $urandom_range(0, 31), 1'b1);
        default: begin
          hs = $urandom_range(36, 62);
          late_all = (1 << (hs - 31)) - 1;
          program_regs($urandom_range(1, 64), $urandom_range(0, late_all - 1),
                       $urandom_range(0, 40), hs, 1'b1);
        end
      endcase
      calm = (p == 5);
      live_items = 0;
      // A frame is queued whole, so each phase stops short of its share.
      while (live_items < ITEM_GOAL / PHASES - FRAME_SLACK) begin
        if ($urandom_range(99) < 80) send_frame($urandom_range(99) < 20);
        else send_noise();
      end
      drain();
    end
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

### ir_pulse_distance_receiver_core.f
+incdir+rtl
rtl/irpd_pkg.sv
rtl/irpd_step.sv
rtl/ir_pulse_distance_receiver_core.sv
tb/sv/ir_pulse_distance_receiver_core_test.sv
